// ===== rtl/pfm_pkg.sv =====
// pfm_pkg: shared types and codes of the packet flow monitor.
// No dependencies; every rtl file but pfm_div refers to it by scoped names.
package pfm_pkg;

   // input word kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   // statistic selectors
   localparam logic [3:0] SEL_PACKETS = 4'd0;
   localparam logic [3:0] SEL_IPV4    = 4'd1;
   localparam logic [3:0] SEL_IPV6    = 4'd2;
   localparam logic [3:0] SEL_TCP     = 4'd3;
   localparam logic [3:0] SEL_UDP     = 4'd4;
   localparam logic [3:0] SEL_SYN     = 4'd5;
   localparam logic [3:0] SEL_FIN     = 4'd6;
   localparam logic [3:0] SEL_RST     = 4'd7;
   localparam logic [3:0] SEL_MAXSRC  = 4'd8;
   localparam logic [3:0] SEL_MINDST  = 4'd9;
   localparam logic [3:0] SEL_FLOWS   = 4'd10;
   localparam logic [3:0] SEL_AVG_LEN = 4'd11;
   localparam logic [3:0] SEL_AVG_PKT = 4'd12;
   localparam logic [3:0] SEL_AVG_BYT = 4'd13;

   // flow status codes
   localparam logic [1:0] FS_MATCH = 2'd0;
   localparam logic [1:0] FS_NEW   = 2'd1;
   localparam logic [1:0] FS_FULL  = 2'd2;
   localparam logic [1:0] FS_NONE  = 2'd3;

   // result kinds
   localparam logic RK_FRAME = 1'b0;
   localparam logic RK_STAT  = 1'b1;

   // register indexes
   localparam logic CSR_SYN_MIN = 1'b0;
   localparam logic CSR_RATIO   = 1'b1;

   localparam logic [15:0] SYN_MIN_RESET = 16'd50;
   localparam logic [7:0]  RATIO_RESET   = 8'd5;
   localparam logic [15:0] PORT_MAX      = 16'hFFFF;
   localparam logic [15:0] ETH_IPV4      = 16'h0800;
   localparam logic [15:0] ETH_IPV6      = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
      logic [3:0] stat_select;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic        flood_alert;
      logic [5:0]  flow_slot;
      logic [1:0]  flow_status;
      logic [31:0] stat_value;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_FRAME,
      OP_CLEAR,
      OP_STAT
   } op_type;

   // classified work handed from front to back; class flags are pre-gated
   typedef struct packed {
      op_type      op;
      logic [3:0]  stat_select;
      logic [15:0] len;
      logic        counted;
      logic        is_v4;
      logic        is_v6;
      logic        is_tcp;
      logic        is_udp;
      logic        l4_good;
      logic        syn;
      logic        fin;
      logic        rst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] sip;
      logic [31:0] dip;
   } task_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_READ,
      ST_COMPARE,
      ST_APPEND,
      ST_MULT,
      ST_FLOOD,
      ST_STAT,
      ST_DIVIDE,
      ST_OUT
   } back_state_type;

endpackage

// ===== rtl/pfm_front.sv =====
// pfm_front: byte-wise header capture and frame classification.
// Depends on pfm_pkg.
module pfm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pfm_pkg::req_word_type word,
   output logic                  push,
   output pfm_pkg::task_type     task_word
);

   logic [15:0] pos_ff, pos_in, len_c;
   logic [7:0]  et_hi_ff, et_hi_in, et_lo_ff, et_lo_in, proto_ff, proto_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [31:0] sip_ff, sip_in, dip_ff, dip_in;
   logic [15:0] sport_ff, sport_in, dport_ff, dport_in;
   logic [2:0]  flags_ff, flags_in;
   logic [15:0] p, l4, l3, l4_len;
   logic [5:0]  hlen;
   logic [7:0]  d;
   logic        cnt, v4, v6, ipok, tcp, udp, l4ok;

   assign p = pos_ff;
   assign d = word.data_byte;

   always_comb begin
      et_hi_in = (p == 16'd12) ? d : et_hi_ff;
      et_lo_in = (p == 16'd13) ? d : et_lo_ff;
      ihl_in   = (p == 16'd14) ? d[3:0] : ihl_ff;
      proto_in = (p == 16'd23) ? d : proto_ff;
      sip_in   = sip_ff;
      dip_in   = dip_ff;
      if (p == 16'd26) sip_in[31:24] = d;
      if (p == 16'd27) sip_in[23:16] = d;
      if (p == 16'd28) sip_in[15:8]  = d;
      if (p == 16'd29) sip_in[7:0]   = d;
      if (p == 16'd30) dip_in[31:24] = d;
      if (p == 16'd31) dip_in[23:16] = d;
      if (p == 16'd32) dip_in[15:8]  = d;
      if (p == 16'd33) dip_in[7:0]   = d;
      // transport offset follows IHL, including the IHL byte itself
      l4       = 16'd14 + {10'd0, ihl_in, 2'b00};
      sport_in = sport_ff;
      dport_in = dport_ff;
      flags_in = flags_ff;
      if (p == l4)          sport_in[15:8] = d;
      if (p == l4 + 16'd1)  sport_in[7:0]  = d;
      if (p == l4 + 16'd2)  dport_in[15:8] = d;
      if (p == l4 + 16'd3)  dport_in[7:0]  = d;
      if (p == l4 + 16'd13) flags_in       = d[2:0];
      len_c = (pos_ff == pfm_pkg::PORT_MAX) ? pos_ff : pos_ff + 16'd1;
      hlen   = {ihl_in, 2'b00};
      l3     = len_c - 16'd14;
      l4_len = l3 - {10'd0, hlen};
      cnt  = (len_c >= 16'd14);
      v6   = cnt && ({et_hi_in, et_lo_in} == pfm_pkg::ETH_IPV6);
      v4   = cnt && ({et_hi_in, et_lo_in} == pfm_pkg::ETH_IPV4);
      ipok = v4 && (l3 >= 16'd20) && (l3 >= {10'd0, hlen});
      tcp  = ipok && (proto_in == pfm_pkg::PROTO_TCP);
      udp  = ipok && (proto_in == pfm_pkg::PROTO_UDP);
      l4ok = (tcp && (l4_len >= 16'd20)) || (udp && (l4_len >= 16'd8));
      pos_in = pos_ff;
      if (accept) begin
         if (word.kind == pfm_pkg::KIND_BYTE) pos_in = word.last ? 16'd0 : len_c;
         else if (word.kind == pfm_pkg::KIND_CLEAR) pos_in = 16'd0;
      end
   end

   always_comb begin
      push = accept && ((word.kind == pfm_pkg::KIND_CLEAR) ||
                        (word.kind == pfm_pkg::KIND_READ) ||
                        ((word.kind == pfm_pkg::KIND_BYTE) && word.last));
      task_word.op = (word.kind == pfm_pkg::KIND_CLEAR) ? pfm_pkg::OP_CLEAR :
                     (word.kind == pfm_pkg::KIND_READ)  ? pfm_pkg::OP_STAT :
                                                          pfm_pkg::OP_FRAME;
      task_word.stat_select = word.stat_select;
      task_word.len     = len_c;
      task_word.counted = cnt;
      task_word.is_v4   = v4;
      task_word.is_v6   = v6;
      task_word.is_tcp  = tcp;
      task_word.is_udp  = udp;
      task_word.l4_good = l4ok;
      task_word.syn     = tcp && l4ok && flags_in[1];
      task_word.fin     = tcp && l4ok && flags_in[0];
      task_word.rst     = tcp && l4ok && flags_in[2];
      task_word.sport   = sport_in;
      task_word.dport   = dport_in;
      task_word.sip     = sip_in;
      task_word.dip     = dip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= 16'd0;
      else       pos_ff <= pos_in;
   end

   always_ff @(posedge clock) begin
      if (accept && (word.kind == pfm_pkg::KIND_BYTE)) begin
         et_hi_ff <= et_hi_in;
         et_lo_ff <= et_lo_in;
         ihl_ff   <= ihl_in;
         proto_ff <= proto_in;
         sip_ff   <= sip_in;
         dip_ff   <= dip_in;
         sport_ff <= sport_in;
         dport_ff <= dport_in;
         flags_ff <= flags_in;
      end
   end

endmodule

// ===== rtl/pfm_queue.sv =====
// pfm_queue: four-entry task queue between front and back.
// Depends on pfm_pkg.
module pfm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pfm_pkg::task_type push_task,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output pfm_pkg::task_type head_task
);

   pfm_pkg::task_type store_ff [4];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] count_ff, count_in;
   logic       do_pop;

   assign full      = (count_ff == 3'd4);
   assign not_empty = (count_ff != 3'd0);
   assign head_task = store_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in    = push ? wr_ff + 2'd1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 2'd1 : rd_ff;
      count_in = count_ff + {2'd0, push} - {2'd0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 2'd0;
         rd_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_task;
   end

endmodule

// ===== rtl/pfm_div.sv =====
// pfm_div: 32-bit restoring divider, one quotient bit per cycle.
// No package dependencies.
module pfm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [32:0] rem_ff, rem_in, trial;
   logic [31:0] q_ff, q_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   assign done     = done_ff;
   assign quotient = q_ff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], q_ff[31]};
      if (start) begin
         rem_in  = 33'd0;
         q_in    = dividend;
         dsr_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            q_in   = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== rtl/pfm_back.sv =====
// pfm_back: statistics, flow table search/append, flood check, stat reads.
// Depends on pfm_pkg and pfm_div.
module pfm_back #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  pfm_pkg::task_type     q_task,
   output logic                  q_pop,
   input  logic [15:0]           syn_min,
   input  logic [7:0]            ratio,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pfm_pkg::rsp_word_type rsp_word
);

   localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int UW = $clog2(FLOW_ENTRIES + 1);
   localparam logic [UW-1:0] USED_MAX = UW'(FLOW_ENTRIES);

   pfm_pkg::back_state_type state_ff, state_in;
   pfm_pkg::task_type task_ff, task_in;
   logic [31:0] pkt_ff, pkt_in, bytes_ff, bytes_in;
   logic [31:0] v4_ff, v4_in, v6_ff, v6_in, tcp_ff, tcp_in, udp_ff, udp_in;
   logic [31:0] syn_ff, syn_in, fin_ff, fin_in, rst_ff, rst_in;
   logic [15:0] maxsrc_ff, maxsrc_in, mindst_ff, mindst_in;
   logic [UW-1:0] used_ff, used_in, idx_ff, idx_in;
   logic [31:0] sump_ff, sump_in, sumb_ff, sumb_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [1:0]  status_ff, status_in;
   logic [40:0] prod_ff, prod_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pfm_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [63:0] flow_mem [FLOW_ENTRIES];
   logic [63:0] rd_ff;
   logic        mem_we;
   logic [31:0] closed, div_a, div_b, div_q;
   logic [8:0]  ratio_p1;
   logic        flow_match, alert, div_start, div_done, l4_good, need_div;

   assign l4_good    = task_ff.l4_good;
   assign flow_match = ((rd_ff[63:32] == task_ff.sip) && (rd_ff[31:0] == task_ff.dip)) ||
                       ((rd_ff[63:32] == task_ff.dip) && (rd_ff[31:0] == task_ff.sip));
   assign closed     = ((fin_ff + rst_ff) == 32'd0) ? 32'd1 : fin_ff + rst_ff;
   assign ratio_p1   = {1'b0, ratio} + 9'd1;
   // floor(syn/closed) > ratio  <=>  syn >= (ratio+1)*closed
   assign alert      = (syn_ff > {16'd0, syn_min}) && ({9'd0, syn_ff} >= prod_ff);
   assign need_div   = ((task_ff.stat_select == pfm_pkg::SEL_AVG_LEN) && (pkt_ff != 32'd0)) ||
                       (((task_ff.stat_select == pfm_pkg::SEL_AVG_PKT) ||
                         (task_ff.stat_select == pfm_pkg::SEL_AVG_BYT)) &&
                        (used_ff != '0));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   pfm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfm_pkg::ST_IDLE:    if (q_valid) state_in = pfm_pkg::ST_UPDATE;
         pfm_pkg::ST_UPDATE: begin
            unique case (task_ff.op)
               pfm_pkg::OP_CLEAR: state_in = pfm_pkg::ST_IDLE;
               pfm_pkg::OP_STAT:  state_in = pfm_pkg::ST_STAT;
               default: begin
                  if (!l4_good)             state_in = pfm_pkg::ST_OUT;
                  else if (used_ff == '0)   state_in = pfm_pkg::ST_APPEND;
                  else                      state_in = pfm_pkg::ST_READ;
               end
            endcase
         end
         pfm_pkg::ST_READ:    state_in = pfm_pkg::ST_COMPARE;
         pfm_pkg::ST_COMPARE: begin
            if (flow_match)                     state_in = pfm_pkg::ST_MULT;
            else if (idx_ff + 1'b1 == used_ff)  state_in = pfm_pkg::ST_APPEND;
            else                                state_in = pfm_pkg::ST_READ;
         end
         pfm_pkg::ST_APPEND:  state_in = pfm_pkg::ST_MULT;
         pfm_pkg::ST_MULT:    state_in = pfm_pkg::ST_FLOOD;
         pfm_pkg::ST_FLOOD:   state_in = pfm_pkg::ST_OUT;
         pfm_pkg::ST_STAT:    state_in = need_div ? pfm_pkg::ST_DIVIDE : pfm_pkg::ST_OUT;
         pfm_pkg::ST_DIVIDE:  if (div_done) state_in = pfm_pkg::ST_OUT;
         pfm_pkg::ST_OUT:     if (!rsp_stall) state_in = pfm_pkg::ST_IDLE;
         default:             state_in = pfm_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      task_in = task_ff;   pkt_in = pkt_ff;     bytes_in = bytes_ff;
      v4_in = v4_ff;       v6_in = v6_ff;       tcp_in = tcp_ff;   udp_in = udp_ff;
      syn_in = syn_ff;     fin_in = fin_ff;     rst_in = rst_ff;
      maxsrc_in = maxsrc_ff; mindst_in = mindst_ff;
      used_in = used_ff;   idx_in = idx_ff;     sump_in = sump_ff; sumb_in = sumb_ff;
      slot_in = slot_ff;   status_in = status_ff; prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      q_pop = 1'b0; mem_we = 1'b0; div_start = 1'b0;
      div_a = bytes_ff; div_b = pkt_ff;
      unique case (state_ff)
         pfm_pkg::ST_IDLE: begin
            q_pop   = q_valid;
            task_in = q_task;
         end
         pfm_pkg::ST_UPDATE: begin
            idx_in    = '0;
            slot_in   = '0;
            status_in = pfm_pkg::FS_NONE;
            if (task_ff.op == pfm_pkg::OP_CLEAR) begin
               pkt_in = '0; bytes_in = '0; v4_in = '0; v6_in = '0;
               tcp_in = '0; udp_in = '0; syn_in = '0; fin_in = '0; rst_in = '0;
               maxsrc_in = '0; mindst_in = pfm_pkg::PORT_MAX;
               used_in = '0; sump_in = '0; sumb_in = '0;
            end else if (task_ff.op == pfm_pkg::OP_FRAME) begin
               if (task_ff.counted) begin
                  pkt_in   = pkt_ff + 32'd1;
                  bytes_in = bytes_ff + {16'd0, task_ff.len};
               end
               if (task_ff.is_v4)  v4_in  = v4_ff + 32'd1;
               if (task_ff.is_v6)  v6_in  = v6_ff + 32'd1;
               if (task_ff.is_tcp) tcp_in = tcp_ff + 32'd1;
               if (task_ff.is_udp) udp_in = udp_ff + 32'd1;
               if (task_ff.syn)    syn_in = syn_ff + 32'd1;
               if (task_ff.fin)    fin_in = fin_ff + 32'd1;
               if (task_ff.rst)    rst_in = rst_ff + 32'd1;
               if (l4_good) begin
                  if (task_ff.sport > maxsrc_ff) maxsrc_in = task_ff.sport;
                  if (task_ff.dport < mindst_ff) mindst_in = task_ff.dport;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{result_kind: pfm_pkg::RK_FRAME, flood_alert: 1'b0,
                             flow_slot: 6'd0, flow_status: pfm_pkg::FS_NONE,
                             stat_value: 32'd0};
               end
            end
         end
         pfm_pkg::ST_COMPARE: begin
            if (flow_match) begin
               status_in = pfm_pkg::FS_MATCH;
               slot_in   = idx_ff[AW-1:0];
               sump_in   = sump_ff + 32'd1;
               sumb_in   = sumb_ff + {16'd0, task_ff.len};
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pfm_pkg::ST_APPEND: begin
            if (used_ff < USED_MAX) begin
               mem_we    = 1'b1;
               status_in = pfm_pkg::FS_NEW;
               slot_in   = used_ff[AW-1:0];
               used_in   = used_ff + 1'b1;
               sump_in   = sump_ff + 32'd1;
               sumb_in   = sumb_ff + {16'd0, task_ff.len};
            end else begin
               status_in = pfm_pkg::FS_FULL;
               slot_in   = '0;
            end
         end
         pfm_pkg::ST_MULT: prod_in = ratio_p1 * closed;
         pfm_pkg::ST_FLOOD: begin
            if (alert) begin
               syn_in = '0; fin_in = '0; rst_in = '0;
            end
            rsp_valid_in = 1'b1;
            rsp_in = '{result_kind: pfm_pkg::RK_FRAME, flood_alert: alert,
                       flow_slot: 6'(slot_ff), flow_status: status_ff,
                       stat_value: 32'd0};
         end
         pfm_pkg::ST_STAT: begin
            rsp_in = '{result_kind: pfm_pkg::RK_STAT, flood_alert: 1'b0, flow_slot: 6'd0,
                       flow_status: pfm_pkg::FS_NONE, stat_value: 32'd0};
            case (task_ff.stat_select)
               pfm_pkg::SEL_PACKETS: rsp_in.stat_value = pkt_ff;
               pfm_pkg::SEL_IPV4:    rsp_in.stat_value = v4_ff;
               pfm_pkg::SEL_IPV6:    rsp_in.stat_value = v6_ff;
               pfm_pkg::SEL_TCP:     rsp_in.stat_value = tcp_ff;
               pfm_pkg::SEL_UDP:     rsp_in.stat_value = udp_ff;
               pfm_pkg::SEL_SYN:     rsp_in.stat_value = syn_ff;
               pfm_pkg::SEL_FIN:     rsp_in.stat_value = fin_ff;
               pfm_pkg::SEL_RST:     rsp_in.stat_value = rst_ff;
               pfm_pkg::SEL_MAXSRC:  rsp_in.stat_value = {16'd0, maxsrc_ff};
               pfm_pkg::SEL_MINDST:  rsp_in.stat_value = {16'd0, mindst_ff};
               pfm_pkg::SEL_FLOWS:   rsp_in.stat_value = 32'(used_ff);
               default:              rsp_in.stat_value = 32'd0;
            endcase
            if (task_ff.stat_select == pfm_pkg::SEL_AVG_PKT) begin
               div_a = sump_ff; div_b = 32'(used_ff);
            end else if (task_ff.stat_select == pfm_pkg::SEL_AVG_BYT) begin
               div_a = sumb_ff; div_b = 32'(used_ff);
            end
            div_start    = need_div;
            rsp_valid_in = !need_div;
         end
         pfm_pkg::ST_DIVIDE: begin
            if (div_done) begin
               rsp_in.stat_value = div_q;
               rsp_valid_in      = 1'b1;
            end
         end
         pfm_pkg::ST_OUT: if (!rsp_stall) rsp_valid_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfm_pkg::ST_IDLE;
         pkt_ff <= '0; bytes_ff <= '0; v4_ff <= '0; v6_ff <= '0;
         tcp_ff <= '0; udp_ff <= '0; syn_ff <= '0; fin_ff <= '0; rst_ff <= '0;
         maxsrc_ff <= '0; mindst_ff <= pfm_pkg::PORT_MAX;
         used_ff <= '0; sump_ff <= '0; sumb_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pkt_ff <= pkt_in; bytes_ff <= bytes_in; v4_ff <= v4_in; v6_ff <= v6_in;
         tcp_ff <= tcp_in; udp_ff <= udp_in; syn_ff <= syn_in; fin_ff <= fin_in;
         rst_ff <= rst_in; maxsrc_ff <= maxsrc_in; mindst_ff <= mindst_in;
         used_ff <= used_in; sump_ff <= sump_in; sumb_ff <= sumb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff   <= task_in;
      idx_ff    <= idx_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   // flow table: IP pair per entry, registered read
   always_ff @(posedge clock) begin
      if (mem_we) flow_mem[used_ff[AW-1:0]] <= {task_ff.sip, task_ff.dip};
      rd_ff <= flow_mem[idx_ff[AW-1:0]];
   end

endmodule

// ===== rtl/packet_flow_monitor_unit.sv =====
// Packet flow monitor: a frame report passes the queue, update, a read and compare per flow
// entry searched, append when none matches, multiply and flood check; without a flow update
// it is reported from update; stat reads pass update and stat, averages also the divider.
// Frame bytes are taken one word per cycle while the task queue has room;
// the back end (flow search, divider) handles one task at a time.
// Reset (synchronous, active high) clears counters, flow count, queue and
// restores syn_min_count 50 and ratio_limit 5; the flow table needs no sweep.
module packet_flow_monitor_unit #(
   parameter int FLOW_ENTRIES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pfm_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata
);

   logic [15:0] syn_min_ff, syn_min_in;
   logic [7:0]  ratio_ff, ratio_in;
   logic        accept, push, q_full, q_valid, q_pop;
   pfm_pkg::task_type push_task, head_task;

   // front stalls only on a full queue; bytes that cause no task still flow
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      syn_min_in = syn_min_ff;
      ratio_in   = ratio_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfm_pkg::CSR_SYN_MIN: syn_min_in = csr_wdata;
            pfm_pkg::CSR_RATIO:   ratio_in   = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         syn_min_ff <= pfm_pkg::SYN_MIN_RESET;
         ratio_ff   <= pfm_pkg::RATIO_RESET;
      end else begin
         syn_min_ff <= syn_min_in;
         ratio_ff   <= ratio_in;
      end
   end

   // front: captures header fields as bytes pass and classifies at frame end
   pfm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (req_word),
      .push      (push),
      .task_word (push_task)
   );

   // decouples byte intake from the multi-cycle back end
   pfm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head_task (head_task)
   );

   // back: counters, flow table, flood check, reads; owns the output register
   pfm_back #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_task    (head_task),
      .q_pop     (q_pop),
      .syn_min   (syn_min_ff),
      .ratio     (ratio_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ===== rtl/pfm_checker.sv =====
// pfm_checker: port-level assertions for the packet flow monitor.
// Depends on pfm_pkg; bound to packet_flow_monitor_unit below.
module pfm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input pfm_pkg::rsp_word_type rsp_word
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stat_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.result_kind == pfm_pkg::RK_STAT) |->
      (rsp_word.flow_status == pfm_pkg::FS_NONE) && !rsp_word.flood_alert &&
      (rsp_word.flow_slot == 6'd0))
      else $error("stat read carries frame fields");

   a_frame_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.result_kind == pfm_pkg::RK_FRAME) |->
      (rsp_word.stat_value == 32'd0))
      else $error("frame report carries stat value");

   a_full_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_word.flow_status == pfm_pkg::FS_FULL) ||
                    (rsp_word.flow_status == pfm_pkg::FS_NONE)) |->
      (rsp_word.flow_slot == 6'd0))
      else $error("slot set without flow entry");

endmodule

bind packet_flow_monitor_unit pfm_checker u_pfm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
